### hdl/msd_pkg.sv
// ----------------------------------------------------------------------------
// msd_pkg
// Widths, register map, item kinds and the result word type shared by the
// multichannel switch debounce filter and its checker.
// ----------------------------------------------------------------------------
package msd_pkg;

   localparam int MASK_W     = 24;
   localparam int CHAN_W     = 5;
   localparam int THR_W      = 10;
   localparam int DBC_W      = 4;
   localparam int GEN_W      = 32;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [THR_W-1:0] THR_RESET = 10'd511;
   localparam logic [DBC_W-1:0] DBC_RESET = 4'd3;

   localparam logic REG_THRESHOLD = 1'b0;
   localparam logic REG_DEBOUNCE  = 1'b1;

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_COMMIT = 1'b1;

   typedef struct packed {
      logic              updated;
      logic [MASK_W-1:0] stable_closed;
      logic [MASK_W-1:0] valid_res;
      logic [MASK_W-1:0] changed;
      logic [GEN_W-1:0]  generation;
   } rsp_type;

endpackage

### hdl/multichannel_switch_debounce.sv
// ----------------------------------------------------------------------------
// multichannel_switch_debounce
// Counter-based debounce filter for a bank of switch inputs read through an
// ADC, with per-channel counters kept in a synchronous memory.
// ----------------------------------------------------------------------------
// Usage: the req channel carries one word per ADC sample (or a commit word
// that loads the debounced masks directly). A scan presents each channel
// once; its last word, and every commit word, produces one rsp word with the
// stable, valid and changed masks, the updated flag and the generation count.
// The csr port holds the closed threshold and the debounce count; write it
// only while no word is in flight.
// Throughput is one req word per cycle while req_ready is high. A word is
// accepted, its channel counter is read from the counter memory at that edge,
// and the next cycle modifies and writes it back; a write to the same channel
// in the cycle before is forwarded. rsp_valid for a resulting word rises once
// the update stage has pushed it into the output queue, which holds it for the receiver.
// A two-word output queue absorbs a stalled receiver; req_ready drops when
// the queued results plus the word in the update stage would fill it.
// Reset clears all masks, counters (through per-entry valid flags) and the
// generation count, and restores the register defaults.
// ----------------------------------------------------------------------------
module multichannel_switch_debounce #(
   parameter int CHANNELS = 24,
   parameter int ADC_BITS = 10
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_kind,
   input  logic [msd_pkg::CHAN_W-1:0]         req_channel,
   input  logic [ADC_BITS-1:0]                req_adc_code,
   input  logic [msd_pkg::MASK_W-1:0]         req_fitted_mask,
   input  logic [msd_pkg::MASK_W-1:0]         req_closed_mask,
   input  logic                               req_first_of_scan,
   input  logic                               req_last_of_scan,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_updated,
   output logic [msd_pkg::MASK_W-1:0]         rsp_stable_closed,
   output logic [msd_pkg::MASK_W-1:0]         rsp_valid_res,
   output logic [msd_pkg::MASK_W-1:0]         rsp_changed,
   output logic [msd_pkg::GEN_W-1:0]          rsp_generation,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [msd_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [msd_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [msd_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   import msd_pkg::*;

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CMP_W = (ADC_BITS > THR_W) ? ADC_BITS : THR_W;
   localparam logic [MASK_W-1:0] CHAN_MASK = (CHANNELS >= MASK_W) ? {MASK_W{1'b1}} :
      MASK_W'((64'd1 << CHANNELS) - 64'd1);

   logic [THR_W-1:0]    thr_ff;
   logic [DBC_W-1:0]    dbc_ff;
   logic                csr_wr;

   logic                req_fire;
   logic                s2_vld_ff;
   logic                s2_kind_ff;
   logic [CHAN_W-1:0]   s2_chan_ff;
   logic [ADC_BITS-1:0] s2_code_ff;
   logic [MASK_W-1:0]   s2_fitted_ff;
   logic [MASK_W-1:0]   s2_closed_ff;
   logic                s2_first_ff;
   logic                s2_last_ff;

   logic [DBC_W-1:0]    cnt_mem [CHANNELS];
   logic [DBC_W-1:0]    cnt_rd_ff;
   logic [CHANNELS-1:0] cnt_set_ff;
   logic [CHANNELS-1:0] cnt_set_in;
   logic                fwd_vld_ff;
   logic [IDX_W-1:0]    fwd_idx_ff;
   logic [DBC_W-1:0]    fwd_data_ff;

   logic [MASK_W-1:0]   cand_ff, cand_in;
   logic [MASK_W-1:0]   stable_ff, stable_in;
   logic [MASK_W-1:0]   valid_ff, valid_in;
   logic [MASK_W-1:0]   change_ff, change_in;
   logic                upd_ff, upd_in;
   logic [GEN_W-1:0]    gen_ff, gen_in;

   logic                wr_en;
   logic [IDX_W-1:0]    wr_idx;
   logic [DBC_W-1:0]    cnt_new;
   logic                push;

   rsp_type             q_ff [2];
   logic                q_wr_ptr_ff;
   logic                q_rd_ptr_ff;
   logic [1:0]          q_cnt_ff;
   logic                pop;
   logic [2:0]          occ;
   rsp_type             head;

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
         dbc_ff <= DBC_RESET;
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_THRESHOLD: thr_ff <= csr_pwdata[THR_W-1:0];
            REG_DEBOUNCE:  dbc_ff <= csr_pwdata[DBC_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_THRESHOLD: csr_prdata = CSR_DATA_W'(thr_ff);
         REG_DEBOUNCE:  csr_prdata = CSR_DATA_W'(dbc_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // Input stage: capture the word and read its channel counter.
   assign occ       = 3'(q_cnt_ff) + 3'(s2_vld_ff) - 3'(pop);
   assign req_ready = !reset && (occ < 3'd2);
   assign req_fire  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= req_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s2_kind_ff   <= req_kind;
         s2_chan_ff   <= req_channel;
         s2_code_ff   <= req_adc_code;
         s2_fitted_ff <= req_fitted_mask;
         s2_closed_ff <= req_closed_mask;
         s2_first_ff  <= req_first_of_scan;
         s2_last_ff   <= req_last_of_scan;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cnt_rd_ff <= cnt_mem[req_channel[IDX_W-1:0]];
      end
      if (wr_en) begin
         cnt_mem[wr_idx] <= cnt_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_set_ff <= '0;
         fwd_vld_ff <= 1'b0;
      end else begin
         cnt_set_ff <= cnt_set_in;
         fwd_vld_ff <= wr_en;
      end
   end

   always_ff @(posedge clock) begin
      fwd_idx_ff  <= wr_idx;
      fwd_data_ff <= cnt_new;
   end

   // Update stage: modify the counter and the channel masks.
   always_comb begin
      logic [MASK_W-1:0] fitted;
      logic [MASK_W-1:0] bit_v;
      logic [MASK_W-1:0] closed;
      logic [MASK_W-1:0] flips;
      logic [DBC_W-1:0]  cnt_old;
      logic              in_range;
      logic              obs;
      logic              cand_bit;

      fitted   = s2_fitted_ff & CHAN_MASK;
      bit_v    = MASK_W'(1) << s2_chan_ff;
      in_range = int'(s2_chan_ff) < CHANNELS;
      wr_idx   = s2_chan_ff[IDX_W-1:0];
      obs      = CMP_W'(s2_code_ff) <= CMP_W'(thr_ff);
      cand_bit = |(cand_ff & bit_v);
      closed   = s2_closed_ff & fitted;
      flips    = (stable_ff ^ closed) & fitted;

      if (fwd_vld_ff && (fwd_idx_ff == wr_idx)) begin
         cnt_old = fwd_data_ff;
      end else if (in_range && cnt_set_ff[wr_idx]) begin
         cnt_old = cnt_rd_ff;
      end else begin
         cnt_old = '0;
      end

      cand_in    = cand_ff;
      stable_in  = stable_ff;
      valid_in   = valid_ff;
      change_in  = change_ff;
      upd_in     = upd_ff;
      gen_in     = gen_ff;
      cnt_new    = cnt_old;
      cnt_set_in = cnt_set_ff;
      wr_en      = 1'b0;
      push       = 1'b0;

      if (s2_vld_ff) begin
         if (s2_kind_ff == KIND_COMMIT) begin
            cand_in   = closed;
            change_in = '0;
            upd_in    = 1'b0;
            if (valid_ff != fitted) begin
               stable_in = closed;
               valid_in  = fitted;
               upd_in    = 1'b1;
            end else if (flips != '0) begin
               stable_in = closed;
               change_in = flips;
               upd_in    = 1'b1;
            end
            push = 1'b1;
         end else begin
            if (s2_first_ff) begin
               change_in = '0;
               upd_in    = 1'b0;
            end
            if (in_range) begin
               wr_en              = 1'b1;
               cnt_set_in[wr_idx] = 1'b1;
               if ((fitted & bit_v) == '0) begin
                  cnt_new   = '0;
                  cand_in   = cand_in & ~bit_v;
                  stable_in = stable_in & ~bit_v;
                  valid_in  = valid_in & ~bit_v;
               end else begin
                  if ((cnt_old == '0) || (cand_bit != obs)) begin
                     cand_in = obs ? (cand_in | bit_v) : (cand_in & ~bit_v);
                     cnt_new = DBC_W'(1);
                  end else if (cnt_old < dbc_ff) begin
                     cnt_new = cnt_old + DBC_W'(1);
                  end
                  if (cnt_new >= dbc_ff) begin
                     if (!(|(valid_ff & bit_v))) begin
                        stable_in = obs ? (stable_in | bit_v) : (stable_in & ~bit_v);
                        valid_in  = valid_in | bit_v;
                        upd_in    = 1'b1;
                     end else if (|(stable_ff & bit_v) != obs) begin
                        stable_in = obs ? (stable_in | bit_v) : (stable_in & ~bit_v);
                        change_in = change_in | bit_v;
                        upd_in    = 1'b1;
                     end
                  end
               end
            end
            if (s2_last_ff) begin
               cand_in   = cand_in & fitted;
               stable_in = stable_in & fitted;
               valid_in  = valid_in & fitted;
               change_in = change_in & fitted;
               push      = 1'b1;
            end
         end
         if (push && upd_in) begin
            gen_in = gen_ff + GEN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff   <= '0;
         stable_ff <= '0;
         valid_ff  <= '0;
         change_ff <= '0;
         upd_ff    <= 1'b0;
         gen_ff    <= '0;
      end else begin
         cand_ff   <= cand_in;
         stable_ff <= stable_in;
         valid_ff  <= valid_in;
         change_ff <= change_in;
         upd_ff    <= upd_in;
         gen_ff    <= gen_in;
      end
   end

   // Output queue.
   assign pop  = rsp_valid && rsp_ready;
   assign head = q_ff[q_rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wr_ptr_ff <= 1'b0;
         q_rd_ptr_ff <= 1'b0;
         q_cnt_ff    <= '0;
      end else begin
         if (push) begin
            q_wr_ptr_ff <= !q_wr_ptr_ff;
         end
         if (pop) begin
            q_rd_ptr_ff <= !q_rd_ptr_ff;
         end
         q_cnt_ff <= q_cnt_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[q_wr_ptr_ff] <= '{updated:       upd_in,
                                stable_closed: stable_in,
                                valid_res:     valid_in,
                                changed:       change_in,
                                generation:    gen_in};
      end
   end

   assign rsp_valid         = q_cnt_ff != '0;
   assign rsp_updated       = head.updated;
   assign rsp_stable_closed = head.stable_closed;
   assign rsp_valid_res     = head.valid_res;
   assign rsp_changed       = head.changed;
   assign rsp_generation    = head.generation;

endmodule

### hdl/msd_checker.sv
// ----------------------------------------------------------------------------
// msd_checker
// Port-level checks for the multichannel switch debounce filter.
// ----------------------------------------------------------------------------
module msd_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [msd_pkg::MASK_W-1:0] rsp_stable_closed,
   input logic [msd_pkg::MASK_W-1:0] rsp_valid_res
);

   import msd_pkg::*;

   // Reset empties the output queue.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // A word held by a stalled receiver is not withdrawn.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("rsp word dropped while stalled");

   // A result from an empty queue comes from a word accepted earlier that has passed the update stage.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("rsp word without a matching req word");

   // A channel can only be reported closed once its state is established.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_stable_closed & ~rsp_valid_res) == '0))
      else $error("stable closed bit outside the valid set");

endmodule

bind multichannel_switch_debounce msd_checker u_msd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_stable_closed (rsp_stable_closed),
   .rsp_valid_res     (rsp_valid_res)
);
